// ----- rtl/quaternion_alu_top_macros.svh -----
// Assertion macros for the quaternion ALU.
`ifndef QUATERNION_ALU_TOP_MACROS_SVH
`define QUATERNION_ALU_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QA_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define QA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/qa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and codes of the quaternion ALU.
package qa_pkg;

   localparam int LANES = 4;
   localparam int QBITS = 32;

   localparam logic [1:0] ACT_ADD = 2'd0;
   localparam logic [1:0] ACT_SUB = 2'd1;
   localparam logic [1:0] ACT_MUL = 2'd2;
   localparam logic [1:0] ACT_DIV = 2'd3;

   localparam logic [1:0] STAT_OK  = 2'd0;
   localparam logic [1:0] STAT_SAT = 2'd1;
   localparam logic [1:0] STAT_DZ  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [31:0] left_real;
      logic signed [31:0] left_i;
      logic signed [31:0] left_j;
      logic signed [31:0] left_k;
      logic signed [31:0] right_real;
      logic signed [31:0] right_i;
      logic signed [31:0] right_j;
      logic signed [31:0] right_k;
   } qa_req_type;

   typedef struct packed {
      logic signed [31:0] out_real;
      logic signed [31:0] out_i;
      logic signed [31:0] out_j;
      logic signed [31:0] out_k;
      logic [1:0]         status;
   } qa_rsp_type;

   typedef struct packed {
      logic is_div;
      logic zero_norm;
   } qa_ctl_type;

   // per-component state carried down the divider
   typedef struct packed {
      logic [31:0] res;     // saturated add/sub/mul result
      logic        sat;
      logic        neg;     // quotient sign
      logic        ovf;     // quotient known to exceed 32 bits
      logic [31:0] dbits;   // dividend bits still to shift in
      logic [31:0] quo;
   } qa_lane_type;

endpackage

// ----- rtl/qa_mult.sv -----
`timescale 1ns / 1ps
// First stage: all component products, squares of the right operand, add/sub.
module qa_mult (
   input  logic               clock,
   input  logic               en,
   input  qa_pkg::qa_req_type req,
   output logic signed [63:0] prod_ff [qa_pkg::LANES][qa_pkg::LANES],
   output logic signed [63:0] sq_ff [qa_pkg::LANES],
   output logic signed [32:0] addsub_ff [qa_pkg::LANES],
   output logic [1:0]         action_ff
);
   import qa_pkg::*;

   logic signed [31:0] lq [LANES];
   logic signed [31:0] rq [LANES];
   logic signed [63:0] prod_in [LANES][LANES];
   logic signed [63:0] sq_in [LANES];
   logic signed [32:0] addsub_in [LANES];

   always_comb begin
      lq[0] = req.left_real;
      lq[1] = req.left_i;
      lq[2] = req.left_j;
      lq[3] = req.left_k;
      rq[0] = req.right_real;
      rq[1] = req.right_i;
      rq[2] = req.right_j;
      rq[3] = req.right_k;
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            prod_in[i][j] = lq[i] * rq[j];
         end
         sq_in[i] = rq[i] * rq[i];
         if (req.action == ACT_SUB) begin
            addsub_in[i] = 33'(lq[i]) - 33'(rq[i]);
         end else begin
            addsub_in[i] = 33'(lq[i]) + 33'(rq[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= prod_in;
         sq_ff     <= sq_in;
         addsub_ff <= addsub_in;
         action_ff <= req.action;
      end
   end

endmodule

// ----- rtl/qa_sum.sv -----
`timescale 1ns / 1ps
// Stages two and three: truncated sums and norm, then saturation and divider setup.
module qa_sum #(
   parameter int FRAC_BITS = 16,
   localparam int NW = 65 - FRAC_BITS
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [63:0]   prod [qa_pkg::LANES][qa_pkg::LANES],
   input  logic signed [63:0]   sq [qa_pkg::LANES],
   input  logic signed [32:0]   addsub [qa_pkg::LANES],
   input  logic [1:0]           action,
   output qa_pkg::qa_lane_type  lane_ff [qa_pkg::LANES],
   output logic [NW-1:0]        rem_ff [qa_pkg::LANES],
   output logic [NW-1:0]        norm_ff,
   output qa_pkg::qa_ctl_type   ctl_ff
);
   import qa_pkg::*;

   localparam int TW = 64 - FRAC_BITS;
   localparam int SW = 66 - FRAC_BITS;
   localparam int MW = 65 - FRAC_BITS;
   localparam int CW = NW + 33;
   localparam logic signed [SW-1:0] SAT_HI = SW'(2147483647);
   localparam logic signed [SW-1:0] SAT_LO = ~SAT_HI;

   // stage two
   logic signed [TW-1:0] t [LANES][LANES];
   logic signed [SW-1:0] x [LANES][LANES];
   logic [NW-1:0]        nt [LANES];
   logic signed [SW-1:0] sum_in [LANES];
   logic [NW-1:0]        norm_in;
   logic signed [SW-1:0] sum_ff [LANES];
   logic [NW-1:0]        norm_a_ff;
   logic [1:0]           act_ff;

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < LANES; j++) begin
            t[i][j] = TW'(prod[i][j] >>> FRAC_BITS);
            x[i][j] = SW'(t[i][j]);
         end
         nt[i] = NW'(sq[i] >>> FRAC_BITS);
      end
      norm_in = nt[0] + nt[1] + nt[2] + nt[3];
      for (int i = 0; i < LANES; i++) begin
         sum_in[i] = '0;
      end
      case (action)
         ACT_ADD, ACT_SUB: begin
            for (int i = 0; i < LANES; i++) begin
               sum_in[i] = SW'(addsub[i]);
            end
         end
         ACT_MUL: begin
            sum_in[0] = x[0][0] - x[1][1] - x[2][2] - x[3][3];
            sum_in[1] = x[0][1] + x[1][0] + x[2][3] - x[3][2];
            sum_in[2] = x[0][2] - x[1][3] + x[2][0] + x[3][1];
            sum_in[3] = x[0][3] + x[1][2] - x[2][1] + x[3][0];
         end
         ACT_DIV: begin
            // left times conjugate of right
            sum_in[0] = x[0][0] + x[1][1] + x[2][2] + x[3][3];
            sum_in[1] = x[1][0] - x[0][1] - x[2][3] + x[3][2];
            sum_in[2] = x[2][0] - x[0][2] - x[3][1] + x[1][3];
            sum_in[3] = x[3][0] - x[0][3] - x[1][2] + x[2][1];
         end
         default: begin
            for (int i = 0; i < LANES; i++) begin
               sum_in[i] = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff    <= sum_in;
         norm_a_ff <= norm_in;
         act_ff    <= action;
      end
   end

   // stage three
   logic [MW-1:0]       mag [LANES];
   logic [64:0]         dvd [LANES];
   qa_lane_type         lane_in [LANES];
   logic [NW-1:0]       rem_in [LANES];
   qa_ctl_type          ctl_in;

   always_comb begin
      ctl_in.is_div    = (act_ff == ACT_DIV);
      ctl_in.zero_norm = ctl_in.is_div && (norm_a_ff == '0);
      for (int i = 0; i < LANES; i++) begin
         lane_in[i].neg = sum_ff[i][SW-1];
         mag[i] = MW'(lane_in[i].neg ? -sum_ff[i] : sum_ff[i]);
         dvd[i] = {mag[i], {FRAC_BITS{1'b0}}};
         lane_in[i].ovf   = CW'(dvd[i][64:32]) >= CW'(norm_a_ff);
         lane_in[i].dbits = dvd[i][31:0];
         lane_in[i].quo   = '0;
         rem_in[i]        = NW'(dvd[i][64:32]);
         if (sum_ff[i] > SAT_HI) begin
            lane_in[i].res = 32'h7FFF_FFFF;
            lane_in[i].sat = 1'b1;
         end else if (sum_ff[i] < SAT_LO) begin
            lane_in[i].res = 32'h8000_0000;
            lane_in[i].sat = 1'b1;
         end else begin
            lane_in[i].res = sum_ff[i][31:0];
            lane_in[i].sat = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         rem_ff  <= rem_in;
         norm_ff <= norm_a_ff;
         ctl_ff  <= ctl_in;
      end
   end

endmodule

// ----- rtl/qa_div_step.sv -----
`timescale 1ns / 1ps
// One restoring-division stage: one quotient bit per component.
module qa_div_step #(
   parameter int NW = 49
) (
   input  logic                clock,
   input  logic                en,
   input  qa_pkg::qa_lane_type lane_i [qa_pkg::LANES],
   input  logic [NW-1:0]       rem_i [qa_pkg::LANES],
   input  logic [NW-1:0]       norm_i,
   input  qa_pkg::qa_ctl_type  ctl_i,
   output qa_pkg::qa_lane_type lane_ff [qa_pkg::LANES],
   output logic [NW-1:0]       rem_ff [qa_pkg::LANES],
   output logic [NW-1:0]       norm_ff,
   output qa_pkg::qa_ctl_type  ctl_ff
);
   import qa_pkg::*;

   logic [NW:0]   trial [LANES];
   logic          qbit [LANES];
   qa_lane_type   lane_in [LANES];
   logic [NW-1:0] rem_in [LANES];

   always_comb begin
      for (int i = 0; i < LANES; i++) begin
         trial[i] = {rem_i[i], lane_i[i].dbits[31]};
         qbit[i]  = trial[i] >= {1'b0, norm_i};
         if (qbit[i]) begin
            rem_in[i] = NW'(trial[i] - {1'b0, norm_i});
         end else begin
            rem_in[i] = NW'(trial[i]);
         end
         lane_in[i]       = lane_i[i];
         lane_in[i].dbits = {lane_i[i].dbits[30:0], 1'b0};
         lane_in[i].quo   = {lane_i[i].quo[30:0], qbit[i]};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         lane_ff <= lane_in;
         rem_ff  <= rem_in;
         norm_ff <= norm_i;
         ctl_ff  <= ctl_i;
      end
   end

endmodule

// ----- rtl/quaternion_alu_top.sv -----
`timescale 1ns / 1ps
// Top level of the quaternion ALU: pipeline, valid tracking, output buffer.
//
//   channel   direction   ports                          transfer when
//   request   in          req_valid req_stall req_data    req_valid & !req_stall
//   response  out         rsp_valid rsp_stall rsp_data    rsp_valid & !rsp_stall
//
// One item per cycle sustained while the output buffer is not full. A request
// passes products, sums, divider setup, then 32 divider stages (one quotient
// bit each) and the output register. Every operation takes the full path.
// Reset clears all valid bits and the output buffer; data registers are not reset.
// The output holds two entries; when both are occupied the whole pipeline holds
// and req_stall is raised, so a stalled response never drops or repeats an item.

`include "quaternion_alu_top_macros.svh"

module quaternion_alu_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  qa_pkg::qa_req_type req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output qa_pkg::qa_rsp_type rsp_data
);
   import qa_pkg::*;

   localparam int NW    = 65 - FRAC_BITS;
   localparam int NPIPE = 3 + QBITS;   // valid bits ahead of the output buffer

   // two-entry output buffer: head drives the port, skid catches one more
   logic       out_valid_ff;
   logic       skid_valid_ff;
   qa_rsp_type out_data_ff;
   qa_rsp_type skid_data_ff;

   // pipeline control: a single advance, taken from registered buffer state
   logic             full;
   logic             adv;
   logic             push;
   logic             pop;
   logic [NPIPE-1:0] v_ff;

   assign full = out_valid_ff && skid_valid_ff;
   assign adv  = !full;
   assign push = v_ff[NPIPE-1] && adv;
   assign pop  = out_valid_ff && !rsp_stall;

   assign req_stall = full;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[NPIPE-2:0], req_valid};
      end
   end

   // stage 1: multipliers
   logic signed [63:0] prod [LANES][LANES];
   logic signed [63:0] sq [LANES];
   logic signed [32:0] addsub [LANES];
   logic [1:0]         action;

   qa_mult u_mult (
      .clock     (clock),
      .en        (adv),
      .req       (req_data),
      .prod_ff   (prod),
      .sq_ff     (sq),
      .addsub_ff (addsub),
      .action_ff (action)
   );

   // stages 2 and 3: sums, norm, saturation, divider setup
   qa_lane_type   lane_s [QBITS+1][LANES];
   logic [NW-1:0] rem_s [QBITS+1][LANES];
   logic [NW-1:0] norm_s [QBITS+1];
   qa_ctl_type    ctl_s [QBITS+1];

   qa_sum #(
      .FRAC_BITS (FRAC_BITS)
   ) u_sum (
      .clock   (clock),
      .en      (adv),
      .prod    (prod),
      .sq      (sq),
      .addsub  (addsub),
      .action  (action),
      .lane_ff (lane_s[0]),
      .rem_ff  (rem_s[0]),
      .norm_ff (norm_s[0]),
      .ctl_ff  (ctl_s[0])
   );

   // divider: one quotient bit per stage, MSB first
   for (genvar k = 0; k < QBITS; k++) begin : g_div
      qa_div_step #(
         .NW (NW)
      ) u_step (
         .clock   (clock),
         .en      (adv),
         .lane_i  (lane_s[k]),
         .rem_i   (rem_s[k]),
         .norm_i  (norm_s[k]),
         .ctl_i   (ctl_s[k]),
         .lane_ff (lane_s[k+1]),
         .rem_ff  (rem_s[k+1]),
         .norm_ff (norm_s[k+1]),
         .ctl_ff  (ctl_s[k+1])
      );
   end

   // result select: zero on zero norm, quotient clamp and sign, or the saturated sum
   logic [31:0] lim [LANES];
   logic [31:0] qv [LANES];
   logic [31:0] comp [LANES];
   logic        lsat [LANES];
   logic        any_sat;
   qa_rsp_type  fin;

   always_comb begin
      any_sat = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         lim[i]  = lane_s[QBITS][i].neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         qv[i]   = lane_s[QBITS][i].quo;
         lsat[i] = 1'b0;
         if (ctl_s[QBITS].zero_norm) begin
            comp[i] = '0;
         end else if (ctl_s[QBITS].is_div) begin
            if (lane_s[QBITS][i].ovf || (lane_s[QBITS][i].quo > lim[i])) begin
               qv[i]   = lim[i];
               lsat[i] = 1'b1;
            end
            comp[i] = lane_s[QBITS][i].neg ? -qv[i] : qv[i];
         end else begin
            comp[i] = lane_s[QBITS][i].res;
            lsat[i] = lane_s[QBITS][i].sat;
         end
         any_sat = any_sat | lsat[i];
      end
      fin.out_real = comp[0];
      fin.out_i    = comp[1];
      fin.out_j    = comp[2];
      fin.out_k    = comp[3];
      if (ctl_s[QBITS].zero_norm) begin
         fin.status = STAT_DZ;
      end else if (any_sat) begin
         fin.status = STAT_SAT;
      end else begin
         fin.status = STAT_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || pop) begin
         out_valid_ff  <= skid_valid_ff || push;
         skid_valid_ff <= skid_valid_ff && push;
      end else if (push) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_data_ff <= skid_data_ff;
            if (push) begin
               skid_data_ff <= fin;
            end
         end else begin
            out_data_ff <= fin;
         end
      end else if (push) begin
         skid_data_ff <= fin;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // checks
   logic rsp_is_zero;
   assign rsp_is_zero = rsp_data.out_real == '0 && rsp_data.out_i == '0 &&
                        rsp_data.out_j == '0 && rsp_data.out_k == '0;

   `QA_ASSERT_IMPL(a_skid_needs_head, skid_valid_ff, out_valid_ff, "skid entry without head entry")
   `QA_ASSERT_NEXT(a_full_freezes_pipe, full && !reset, $stable(v_ff), "pipeline moved while full")
   `QA_ASSERT_IMPL(a_dz_zero_result, rsp_valid && rsp_data.status == STAT_DZ, rsp_is_zero, "dz nonzero")
   `QA_ASSERT_IMPL(a_status_code, rsp_valid, rsp_data.status != 2'd3, "unused status code")

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the quaternion ALU top level.
module testbench;
   import qa_pkg::*;

   localparam int FRAC     = 16;
   localparam int LATENCY  = 35;
   localparam int MAX_CYC  = 400000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   qa_req_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   qa_rsp_type rsp_data;

   // predicted responses, oldest first
   qa_rsp_type quat_expected[$];
   int         errors = 0;
   int         cycles = 0;
   bit         quiet_mode = 1'b0;   // no idling on either side while set

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   quaternion_alu_top #(.FRAC_BITS(FRAC)) DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // ---------------------------------------------------------------------
   // Predictor arithmetic
   // ---------------------------------------------------------------------

   // product of two Q16.16 values, floor back to Q16.16
   function automatic longint fix_mul(longint x, longint y);
      longint p;
      p = x * y;
      return p >>> FRAC;
   endfunction

   function automatic logic [31:0] clamp32(longint v, ref bit flag);
      if (v > 64'sd2147483647) begin
         flag = 1'b1;
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         flag = 1'b1;
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

   // num * 2^FRAC / n, truncated toward zero, then clamped
   function automatic logic [31:0] fix_div(longint num, longint n, ref bit flag);
      bit          neg;
      logic [63:0] mag, q, lim;
      neg = num < 0;
      mag = neg ? -num : num;
      lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
      if (mag / n >= 64'h1_0000_0000) begin
         q = lim;
         flag = 1'b1;
      end else begin
         q = ((mag / n) << FRAC) + (((mag % n) << FRAC) / n);
         if (q > lim) begin
            q = lim;
            flag = 1'b1;
         end
      end
      q = neg ? -q : q;
      return q[31:0];
   endfunction

   function automatic qa_rsp_type quat_predict(qa_req_type r);
      qa_rsp_type o;
      longint a1, b1, c1, d1, a2, b2, c2, d2, sg, n;
      bit sat;
      a1 = r.left_real;  b1 = r.left_i;  c1 = r.left_j;  d1 = r.left_k;
      a2 = r.right_real; b2 = r.right_i; c2 = r.right_j; d2 = r.right_k;
      sat = 1'b0;
      o.status = STAT_OK;
      case (r.action)
         ACT_ADD, ACT_SUB: begin
            sg = (r.action == ACT_ADD) ? 1 : -1;
            o.out_real = clamp32(a1 + sg * a2, sat);
            o.out_i    = clamp32(b1 + sg * b2, sat);
            o.out_j    = clamp32(c1 + sg * c2, sat);
            o.out_k    = clamp32(d1 + sg * d2, sat);
         end
         ACT_MUL: begin
            o.out_real = clamp32(fix_mul(a1, a2) - fix_mul(b1, b2) - fix_mul(c1, c2)
                                 - fix_mul(d1, d2), sat);
            o.out_i    = clamp32(fix_mul(a1, b2) + fix_mul(b1, a2) + fix_mul(c1, d2)
                                 - fix_mul(d1, c2), sat);
            o.out_j    = clamp32(fix_mul(a1, c2) - fix_mul(b1, d2) + fix_mul(c1, a2)
                                 + fix_mul(d1, b2), sat);
            o.out_k    = clamp32(fix_mul(a1, d2) + fix_mul(b1, c2) - fix_mul(c1, b2)
                                 + fix_mul(d1, a2), sat);
         end
         default: begin
            n = fix_mul(a2, a2) + fix_mul(b2, b2) + fix_mul(c2, c2) + fix_mul(d2, d2);
            if (n <= 0) begin
               o = '0;
               o.status = STAT_DZ;
               return o;
            end
            o.out_real = fix_div(fix_mul(a1, a2) + fix_mul(b1, b2) + fix_mul(c1, c2)
                                 + fix_mul(d1, d2), n, sat);
            o.out_i    = fix_div(fix_mul(a2, b1) - fix_mul(a1, b2)
                                 - (fix_mul(c1, d2) - fix_mul(d1, c2)), n, sat);
            o.out_j    = fix_div(fix_mul(a2, c1) - fix_mul(a1, c2)
                                 - (fix_mul(d1, b2) - fix_mul(b1, d2)), n, sat);
            o.out_k    = fix_div(fix_mul(a2, d1) - fix_mul(a1, d2)
                                 - (fix_mul(b1, c2) - fix_mul(c1, b2)), n, sat);
         end
      endcase
      if (sat)
         o.status = STAT_SAT;
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Response side: random stall, compare on each transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      qa_rsp_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (quat_expected.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_data);
               errors++;
            end else begin
               want = quat_expected.pop_front();
               if (rsp_data.out_real !== want.out_real) begin
                  $display("%0t: out_real expected %h actual %h", $time,
                           want.out_real, rsp_data.out_real);
                  errors++;
               end
               if (rsp_data.out_i !== want.out_i) begin
                  $display("%0t: out_i expected %h actual %h", $time,
                           want.out_i, rsp_data.out_i);
                  errors++;
               end
               if (rsp_data.out_j !== want.out_j) begin
                  $display("%0t: out_j expected %h actual %h", $time,
                           want.out_j, rsp_data.out_j);
                  errors++;
               end
               if (rsp_data.out_k !== want.out_k) begin
                  $display("%0t: out_k expected %h actual %h", $time,
                           want.out_k, rsp_data.out_k);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time,
                           want.status, rsp_data.status);
                  errors++;
               end
            end
         end
      end
      // stall is the receiver's own choice, independent of rsp_valid
      rsp_stall <= !quiet_mode && ($urandom_range(99) < 27);
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > MAX_CYC) begin
         $display("[quaternion_alu_top] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Request side
   // ---------------------------------------------------------------------

   // one transfer, with random idle cycles ahead of it
   task automatic quat_send(qa_req_type r);
      while (!quiet_mode && ($urandom_range(99) < 27)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do
         @(posedge clock);
      while (req_stall);
      quat_expected.push_back(quat_predict(r));
   endtask

   function automatic logic [31:0] rand_comp(int mode);
      case (mode)
         0: return $urandom();
         1: return $signed($urandom_range(32'h0004_0000)) - 32'sh0002_0000;
         2: return $signed($urandom_range(32'h0100_0000)) - 32'sh0080_0000;
         3: return $signed($urandom_range(255)) - 128;
         4: return ($urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000);
         default: return '0;
      endcase
   endfunction

   function automatic qa_req_type quat_build(logic [1:0] act, int mode);
      qa_req_type r;
      r.action     = act;
      r.left_real  = rand_comp(mode == 5 ? $urandom_range(4) : mode);
      r.left_i     = rand_comp(mode == 5 ? $urandom_range(4) : mode);
      r.left_j     = rand_comp(mode == 5 ? $urandom_range(4) : mode);
      r.left_k     = rand_comp(mode == 5 ? $urandom_range(4) : mode);
      r.right_real = rand_comp(mode == 5 ? $urandom_range(5) : mode);
      r.right_i    = rand_comp(mode == 5 ? $urandom_range(5) : mode);
      r.right_j    = rand_comp(mode == 5 ? $urandom_range(5) : mode);
      r.right_k    = rand_comp(mode == 5 ? $urandom_range(5) : mode);
      return r;
   endfunction

   function automatic qa_req_type quat_fill(logic [1:0] act, logic [31:0] lv, logic [31:0] rv);
      qa_req_type r;
      r.action = act;
      r.left_real = lv; r.left_i = lv; r.left_j = lv; r.left_k = lv;
      r.right_real = rv; r.right_i = rv; r.right_j = rv; r.right_k = rv;
      return r;
   endfunction

   // extremes and saturation on every operation
   task automatic test_extremes();
      logic [1:0] act;
      for (int a = 0; a < 4; a++) begin
         act = a[1:0];
         quat_send(quat_fill(act, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
         quat_send(quat_fill(act, 32'h8000_0000, 32'h8000_0000));
         quat_send(quat_fill(act, 32'h8000_0000, 32'h7FFF_FFFF));
         quat_send(quat_fill(act, 32'h0001_0000, 32'hFFFF_0000));
      end
   endtask

   // zero norm: exact zero divisor and two whose squares all truncate away
   task automatic test_zero_norm();
      quat_send(quat_fill(ACT_DIV, 32'h0003_0000, 32'h0));
      quat_send(quat_fill(ACT_DIV, 32'h7FFF_FFFF, 32'h0000_00FF));
      quat_send(quat_fill(ACT_DIV, 32'h8000_0000, 32'hFFFF_FF01));
      // tiny divisor whose norm survives: large quotient saturates
      quat_send(quat_fill(ACT_DIV, 32'h0100_0000, 32'h0000_0100));
      // unit operands
      quat_send(quat_fill(ACT_MUL, 32'h0001_0000, 32'h0001_0000));
      quat_send(quat_fill(ACT_DIV, 32'hFFFF_0000, 32'h0001_0000));
   endtask

   // random mix, one stretch without idling on either side
   task automatic test_random();
      for (int n = 0; n < 600; n++) begin
         quiet_mode = (n >= 250 && n < 330);
         quat_send(quat_build(2'($urandom_range(3)), $urandom_range(5)));
      end
      quiet_mode = 1'b0;
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extremes();
      test_zero_norm();
      test_random();
      req_valid <= 1'b0;
      // drain, then wait on for stray responses
      while (quat_expected.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0)
         $display("[quaternion_alu_top] OK");
      else
         $display("[quaternion_alu_top] ERROR");
      $finish;
   end

endmodule
